// ===== sv/qpht_pkg.sv =====
// Shared types and constants for the quadratic probe hash table.
`default_nettype none

package qpht_pkg;

    localparam int KEY_W     = 31;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 3;
    localparam int IDX_W     = 4;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 8;

    // remainder unit: width of the reciprocal constant
    localparam int RECIP_W   = 32;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DEL_MISS  = 3'd5;

    typedef struct packed {
        logic init;
        logic step;
    } t_gen_ctl;

endpackage

`default_nettype wire

// ===== sv/qpht_mod.sv =====
// Remainder unit: key modulo the table size by reciprocal multiplication.
`default_nettype none

module qpht_mod
    import qpht_pkg::*;
#(
    parameter int TABLE_SLOTS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [KEY_W-1:0]  i_key,
    output logic                   o_done,
    output logic [$clog2(TABLE_SLOTS)-1:0] o_home
);

    localparam int SW = $clog2(TABLE_SLOTS);
    localparam int SH = KEY_W + SW;
    localparam int PW = KEY_W + RECIP_W;
    // ceil(2^SH / TABLE_SLOTS) gives the exact quotient for every key
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SH) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS));

    logic             r_v1;
    logic             r_v2;
    logic             r_done;
    logic [KEY_W-1:0] r_key;
    logic [PW-1:0]    r_prod;
    logic [KEY_W-1:0] r_qn;
    logic [SW-1:0]    r_rem;
    logic [KEY_W-1:0] w_quot;
    logic [KEY_W-1:0] w_diff;

    assign w_quot = KEY_W'(r_prod >> SH);
    assign w_diff = r_key - r_qn;

    // three stages: product, quotient times size, difference
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_v2   <= r_v1;
            r_done <= r_v2;
        end
        if (i_start) begin
            r_key  <= i_key;
            r_prod <= PW'(i_key) * PW'(RECIP);
        end
        if (r_v1) begin
            r_qn <= w_quot * KEY_W'(TABLE_SLOTS);
        end
        if (r_v2) begin
            r_rem <= w_diff[SW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_home = r_rem;

endmodule

`default_nettype wire

// ===== sv/qpht_probe_gen.sv =====
// Probe address generator: home plus i squared, modulo the table size.
`default_nettype none

module qpht_probe_gen
    import qpht_pkg::*;
#(
    parameter int TABLE_SLOTS = 16
) (
    input  wire logic                          i_clk,
    input  wire t_gen_ctl                      i_ctl,
    input  wire logic [$clog2(TABLE_SLOTS)-1:0] i_home,
    output logic [$clog2(TABLE_SLOTS)-1:0]     o_slot
);

    localparam int SW = $clog2(TABLE_SLOTS);
    localparam int RW = SW + 1;
    localparam logic [RW-1:0] MOD_N = RW'(TABLE_SLOTS);

    logic [SW-1:0] r_home;
    logic [SW-1:0] r_off;
    logic [SW-1:0] r_inc;
    logic [SW-1:0] n_off;
    logic [SW-1:0] n_inc;
    logic [RW-1:0] w_sum;
    logic [RW-1:0] w_osum;
    logic [RW-1:0] w_isum;

    // (i+1)^2 = i^2 + (2i+1); the odd increment steps by two
    always_comb begin
        w_sum  = {1'b0, r_home} + {1'b0, r_off};
        if (w_sum >= MOD_N) begin
            w_sum = w_sum - MOD_N;
        end
        w_osum = {1'b0, r_off} + {1'b0, r_inc};
        if (w_osum >= MOD_N) begin
            w_osum = w_osum - MOD_N;
        end
        w_isum = {1'b0, r_inc} + RW'(2);
        if (w_isum >= MOD_N) begin
            w_isum = w_isum - MOD_N;
        end
        n_off = w_osum[SW-1:0];
        n_inc = w_isum[SW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_home <= i_home;
            r_off  <= '0;
            r_inc  <= SW'(1);
        end else if (i_ctl.step) begin
            r_off <= n_off;
            r_inc <= n_inc;
        end
    end

    assign o_slot = w_sum[SW-1:0];

endmodule

`default_nettype wire

// ===== sv/quadratic_probe_hash_table_top.sv =====
// Quadratic probe hash table: request channel, result channel and slot memory.
//
// Requests arrive on the s_axis channel: tuser carries the command (insert,
// search, delete), tdata the 31-bit key. Each request gives exactly one
// result on the m_axis channel: tuser carries the status, tdata the slot.
// One request is worked on at a time. After acceptance the key is reduced
// modulo TABLE_SLOTS by a three-stage reciprocal-multiply remainder unit,
// then the slot memory is read once per cycle along the probe sequence,
// each read checked in the cycle after it. Probing ends at the first hit,
// or when all TABLE_SLOTS + 1 probes miss; the result then goes to the
// output register, and the next request can be accepted in the same cycle
// as that result appears on m_axis.
// The single read port of the slot memory sets the probe rate.
// After reset the block sweeps the slot memory to mark every slot empty
// and holds s_axis tready low meanwhile.
// The result sits in an output register; the next request is accepted while
// it waits, and only the finishing step of that request waits on m_axis
// tready.
`default_nettype none

module quadratic_probe_hash_table_top
    import qpht_pkg::*;
#(
    parameter int TABLE_SLOTS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_axis_tdata,  // key
    input  wire logic [CMD_W-1:0]     i_s_axis_tuser,  // cmd
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0]      o_m_axis_tdata,  // slot_index
    output logic [STATUS_W-1:0]       o_m_axis_tuser   // status
);

    localparam int SW = $clog2(TABLE_SLOTS);
    localparam int CW = $clog2(TABLE_SLOTS + 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_PROBE,
        S_DONE
    } t_state;

    t_state               r_state;
    logic [SW-1:0]        r_clr;
    logic [CMD_W-1:0]     r_cmd;
    logic [KEY_W-1:0]     r_key;
    logic [CW-1:0]        r_i;
    logic                 r_issue_on;
    logic                 r_chk_vld;
    logic                 r_chk_last;
    logic [SW-1:0]        r_chk_slot;
    logic [STATUS_W-1:0]  r_status;
    logic [IDX_W-1:0]     r_idx;
    logic                 r_m_tvalid;
    logic [STATUS_W-1:0]  r_m_status;
    logic [IDX_W-1:0]     r_m_idx;

    logic [KEY_W:0]       r_mem [TABLE_SLOTS];
    logic [KEY_W:0]       r_rd_data;

    logic                 w_mod_start;
    logic                 w_mod_done;
    logic [SW-1:0]        w_home;
    t_gen_ctl             w_gen_ctl;
    logic [SW-1:0]        w_slot;
    logic                 w_i_last;
    logic                 w_hit;
    logic                 w_modify;
    logic                 w_we;
    logic [SW-1:0]        w_waddr;
    logic [KEY_W:0]       w_wdata;
    logic [STATUS_W-1:0]  w_res_status;

    assign w_mod_start    = (r_state == S_IDLE) && i_s_axis_tvalid;
    assign w_gen_ctl.init = (r_state == S_MOD) && w_mod_done;
    assign w_gen_ctl.step = (r_state == S_PROBE) && r_issue_on;
    assign w_i_last       = (r_i == CW'(TABLE_SLOTS));

    qpht_mod #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) u_mod (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_mod_start),
        .i_key  (i_s_axis_tdata[KEY_W-1:0]),
        .o_done (w_mod_done),
        .o_home (w_home)
    );

    qpht_probe_gen #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) u_gen (
        .i_clk (i_clk),
        .i_ctl (w_gen_ctl),
        .i_home(w_home),
        .o_slot(w_slot)
    );

    always_comb begin
        if (r_cmd == CMD_INSERT) begin
            w_hit = !r_rd_data[KEY_W];
        end else begin
            w_hit = r_rd_data[KEY_W] && (r_rd_data[KEY_W-1:0] == r_key);
        end
        w_modify = (r_cmd == CMD_INSERT) || (r_cmd == CMD_DELETE);
        case (r_cmd)
            CMD_INSERT: w_res_status = w_hit ? ST_INSERTED : ST_FULL;
            CMD_DELETE: w_res_status = w_hit ? ST_DELETED : ST_DEL_MISS;
            default:    w_res_status = w_hit ? ST_FOUND : ST_NOT_FOUND;
        endcase
        if (r_state == S_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
            w_wdata = '0;
        end else begin
            w_we    = (r_state == S_PROBE) && r_chk_vld && w_hit && w_modify;
            w_waddr = r_chk_slot;
            w_wdata = {(r_cmd == CMD_INSERT), r_key};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_mem[w_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_issue_on <= 1'b0;
            r_chk_vld  <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            if (r_m_tvalid && i_m_axis_tready && (r_state != S_DONE)) begin
                r_m_tvalid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + SW'(1);
                    if (r_clr == SW'(TABLE_SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_cmd   <= i_s_axis_tuser;
                        r_key   <= i_s_axis_tdata[KEY_W-1:0];
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (w_mod_done) begin
                        r_i        <= '0;
                        r_issue_on <= 1'b1;
                        r_chk_vld  <= 1'b0;
                        r_state    <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    r_chk_slot <= w_slot;
                    r_chk_last <= w_i_last;
                    if (r_chk_vld && (w_hit || r_chk_last)) begin
                        r_status   <= w_res_status;
                        r_idx      <= w_hit ? IDX_W'(r_chk_slot) : '0;
                        r_chk_vld  <= 1'b0;
                        r_issue_on <= 1'b0;
                        r_state    <= S_DONE;
                    end else begin
                        r_chk_vld <= r_issue_on;
                        if (r_issue_on) begin
                            r_i <= r_i + CW'(1);
                            if (w_i_last) begin
                                r_issue_on <= 1'b0;
                            end
                        end
                    end
                end
                S_DONE: begin
                    if (!r_m_tvalid || i_m_axis_tready) begin
                        r_m_tvalid <= 1'b1;
                        r_m_status <= r_status;
                        r_m_idx    <= r_idx;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = M_TDATA_W'(r_m_idx);
    assign o_m_axis_tuser  = r_m_status;

`ifndef NO_ASSERTIONS
    a_chk_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_vld |-> (32'(r_chk_slot) < TABLE_SLOTS))
        else $error("probe slot out of range");

    a_mod_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_done |-> (r_state == S_MOD))
        else $error("remainder done outside of MOD");

    a_write_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && (r_state != S_CLEAR)) |-> (r_cmd == CMD_INSERT || r_cmd == CMD_DELETE))
        else $error("memory write by a search");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside of DONE");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> !o_s_axis_tready)
        else $error("request accepted during probing");
`endif

endmodule

`default_nettype wire

// ===== tb/quadratic_probe_hash_table_top_tb.sv =====
// Self-checking testbench for the quadratic probe hash table top level.
`timescale 1ns / 100ps

module quadratic_probe_hash_table_top_tb;
    import qpht_pkg::*;

    localparam int SLOTS       = 16;
    localparam int N_RANDOM    = 500;
    localparam int POOL_SIZE   = 20;
    localparam int IDLE_PCT    = 37;
    localparam int CALM_FIRST  = 200;
    localparam int CALM_LAST   = 300;
    localparam int DRAIN_AT    = 250;
    localparam int TAIL_CYCLES = 4 * (SLOTS + 13);

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
        logic             drain;
    } t_hash_req;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    slot;
    } t_hash_result;

    logic                 i_clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [CMD_W-1:0]     s_tuser = '0;
    logic                 m_tready = 1'b0;
    logic                 o_s_axis_tready;
    logic                 o_m_axis_tvalid;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;
    logic [STATUS_W-1:0]  o_m_axis_tuser;

    t_hash_req    req_q[$];
    t_hash_result result_q[$];

    logic             slot_used[SLOTS];
    logic [KEY_W-1:0] slot_key[SLOTS];
    logic [KEY_W-1:0] key_pool[POOL_SIZE];

    int sent_count  = 0;
    int recv_count  = 0;
    int fail_count  = 0;
    int status_seen[8];

    quadratic_probe_hash_table_top #(
        .TABLE_SLOTS(SLOTS)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),   // [30:0] key, [31] zero
        .i_s_axis_tuser  (s_tuser),   // [1:0] cmd
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),  // [3:0] slot_index, [7:4] zero
        .o_m_axis_tuser  (o_m_axis_tuser)   // [2:0] status
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_hash_result hash_table_lookup(input logic [CMD_W-1:0] cmd,
                                                       input logic [KEY_W-1:0] key);
        t_hash_result r;
        int unsigned  home;
        int unsigned  s;
        int unsigned  where;
        logic         hit;
        logic         want_empty;
        home       = key % SLOTS;
        where      = 0;
        hit        = 1'b0;
        want_empty = (cmd == CMD_INSERT);
        for (int unsigned i = 0; i <= SLOTS && !hit; i++) begin
            s = (home + (i * i) % SLOTS) % SLOTS;
            if (want_empty ? !slot_used[s] : (slot_used[s] && slot_key[s] == key)) begin
                hit   = 1'b1;
                where = s;
            end
        end
        case (cmd)
            CMD_INSERT: begin
                r.status = hit ? ST_INSERTED : ST_FULL;
                if (hit) begin
                    slot_used[where] = 1'b1;
                    slot_key[where]  = key;
                end
            end
            CMD_DELETE: begin
                r.status = hit ? ST_DELETED : ST_DEL_MISS;
                if (hit) begin
                    slot_used[where] = 1'b0;
                end
            end
            default: begin
                r.status = hit ? ST_FOUND : ST_NOT_FOUND;
            end
        endcase
        r.slot = hit ? where[IDX_W-1:0] : '0;
        return r;
    endfunction

    task automatic add_req(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                           input logic drain = 1'b0);
        t_hash_req q;
        q.cmd   = cmd;
        q.key   = key;
        q.drain = drain;
        req_q.push_back(q);
    endtask

    // request driver; prediction happens at acceptance
    always @(posedge i_clk) begin : drive_proc
        logic         fire;
        logic         gap;
        t_hash_result res;
        fire = s_tvalid && o_s_axis_tready;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (fire) begin
                res = hash_table_lookup(s_tuser, s_tdata[KEY_W-1:0]);
                result_q.push_back(res);
                void'(req_q.pop_front());
                sent_count++;
            end
            if (!s_tvalid || fire) begin
                gap = ($urandom_range(0, 99) < IDLE_PCT) &&
                      !(sent_count >= CALM_FIRST && sent_count < CALM_LAST);
                if (req_q.size() != 0 && !gap &&
                    !(req_q[0].drain && result_q.size() != 0)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {1'b0, req_q[0].key};
                    s_tuser  <= req_q[0].cmd;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin : monitor_proc
        t_hash_result exp_res;
        logic         stall;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && m_tready) begin
                if (result_q.size() == 0) begin
                    $error("unexpected item: status %0d slot_index %0d",
                           o_m_axis_tuser, o_m_axis_tdata);
                    fail_count++;
                end else begin
                    exp_res = result_q.pop_front();
                    if (o_m_axis_tuser !== exp_res.status) begin
                        $error("status: expected %0d, actual %0d",
                               exp_res.status, o_m_axis_tuser);
                        fail_count++;
                    end
                    if (o_m_axis_tdata !== M_TDATA_W'(exp_res.slot)) begin
                        $error("slot_index: expected %0d, actual %0d",
                               exp_res.slot, o_m_axis_tdata);
                        fail_count++;
                    end
                    status_seen[exp_res.status]++;
                end
                recv_count++;
            end
            stall = ($urandom_range(0, 99) < IDLE_PCT) &&
                    !(recv_count >= CALM_FIRST && recv_count < CALM_LAST);
            m_tready <= !stall;
        end
    end

    initial begin : stim_proc
        int               pick;
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
        foreach (slot_used[i]) slot_used[i] = 1'b0;
        foreach (status_seen[i]) status_seen[i] = 0;
        for (int k = 0; k < POOL_SIZE; k++) begin
            key_pool[k] = KEY_W'($urandom & 32'h7FFF_FFF0) | KEY_W'(k % 6);
        end

        // directed: home-0 collisions, full probe path, duplicates, unused cmd
        add_req(CMD_INSERT, 31'd0);
        add_req(CMD_INSERT, 31'h7FFF_FFFF);
        add_req(CMD_INSERT, 31'd16);
        add_req(CMD_INSERT, 31'd32);
        add_req(CMD_INSERT, 31'd48);
        add_req(CMD_INSERT, 31'd64);
        add_req(CMD_SEARCH, 31'h7FFF_FFFF);
        add_req(CMD_SEARCH, 31'd5);
        add_req(CMD_UNUSED, 31'd16);
        add_req(CMD_DELETE, 31'd16);
        add_req(CMD_DELETE, 31'd16);
        add_req(CMD_SEARCH, 31'd32);
        add_req(CMD_INSERT, 31'd0);
        add_req(CMD_SEARCH, 31'd0);
        add_req(CMD_DELETE, 31'd0);
        add_req(CMD_SEARCH, 31'd0);
        add_req(CMD_DELETE, 31'h7FFF_FFFF);
        add_req(CMD_DELETE, 31'd5);
        add_req(CMD_UNUSED, 31'h5555_5555);
        add_req(CMD_INSERT, 31'h2AAA_AAAA);
        add_req(CMD_UNUSED, 31'h2AAA_AAAA);

        for (int n = 0; n < N_RANDOM; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) cmd = CMD_INSERT;
            else if (pick < 70) cmd = CMD_DELETE;
            else if (pick < 95) cmd = CMD_SEARCH;
            else cmd = CMD_UNUSED;
            if ($urandom_range(0, 9) == 0) key = KEY_W'($urandom);
            else key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            add_req(cmd, key, n == DRAIN_AT);
        end

        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;

        wait (req_q.size() == 0 && !s_tvalid);
        wait (result_q.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (result_q.size() != 0) begin
            $error("%0d results never arrived", result_q.size());
            fail_count++;
        end

        $display("%0d requests sent, %0d results checked, %0d mismatches",
                 sent_count, recv_count, fail_count);
        $display("inserted %0d, full %0d, found %0d, not found %0d, deleted %0d, miss %0d",
                 status_seen[ST_INSERTED], status_seen[ST_FULL], status_seen[ST_FOUND],
                 status_seen[ST_NOT_FOUND], status_seen[ST_DELETED],
                 status_seen[ST_DEL_MISS]);
        if (fail_count == 0) begin
            $display("quadratic_probe_hash_table_top test passed");
        end else begin
            $display("quadratic_probe_hash_table_top test failed");
        end
        $finish;
    end

    initial begin : watchdog_proc
        #2ms;
        $display("quadratic_probe_hash_table_top test failed");
        $finish;
    end

endmodule
